FILE: rtl/core/fdm_pkg.sv
// Shared constants for the feedback delay mix unit.
// Register indexes, field widths and reset values; no dependencies.
`default_nettype none

package fdm_pkg;

    // Default sizes of the echo store and of one audio sample
    localparam int DEPTH_DEFAULT       = 4096;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WET      = 2'd2;

    // Field widths of the registers
    localparam int DELAY_W = 12;
    localparam int GAIN_W  = 16;

    // Q1.15 gain arithmetic
    localparam int                GAIN_SHIFT = 15;
    localparam int                ROUND_BIAS = 1 << (GAIN_SHIFT - 1);
    localparam logic [GAIN_W-1:0] GAIN_ONE   = 16'h8000;

    // Reset values of the registers
    localparam int                       DELAY_RESET    = 4095;
    localparam logic signed [GAIN_W-1:0] FEEDBACK_RESET = 16'sd26214;
    localparam logic [GAIN_W-1:0]        WET_RESET      = 16'h8000;

endpackage

`default_nettype wire

FILE: rtl/core/fdm_delay_mod.sv
// Delay reduction unit: takes the written delay modulo the store depth by
// reciprocal multiplication, product then remainder. Depends on fdm_pkg.
`default_nettype none

module fdm_delay_mod #(
    parameter int DEPTH = fdm_pkg::DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             load,
    input  wire logic [fdm_pkg::DELAY_W-1:0]      load_value,
    output logic                                  busy,
    output logic [$clog2(DEPTH)-1:0]              delay_mod
);
    import fdm_pkg::*;

    localparam int     ADDR_W     = $clog2(DEPTH);
    localparam int     RECIP_SH   = DELAY_W + ADDR_W;
    localparam int     RECIP_W    = DELAY_W + 2;
    localparam int     PROD_W     = DELAY_W + RECIP_W;
    localparam longint RECIP_FULL = ((longint'(1) << RECIP_SH) + longint'(DEPTH) - 1)
                                  / longint'(DEPTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam int     RESET_MOD  = DELAY_RESET % DEPTH;

    logic [DELAY_W-1:0] val_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               busy_reg;
    logic [ADDR_W-1:0]  rem_reg;
    logic [DELAY_W-1:0] quot;
    logic [ADDR_W-1:0]  rem_next;

    // Quotient is exact for every delay value; the remainder is below DEPTH
    assign quot     = DELAY_W'(prod_reg >> RECIP_SH);
    assign rem_next = ADDR_W'(val_reg - DELAY_W'(int'(quot) * DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg  <= '0;
            prod_reg <= '0;
            busy_reg <= 1'b0;
            rem_reg  <= ADDR_W'(RESET_MOD);
        end
        else if (load)
        begin
            val_reg  <= load_value;
            prod_reg <= PROD_W'(load_value) * PROD_W'(RECIP);
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            busy_reg <= 1'b0;
        end
    end

    assign busy      = busy_reg;
    assign delay_mod = rem_reg;

endmodule

`default_nettype wire

FILE: rtl/core/fdm_echo_mem.sv
// Echo store: simple dual-port memory, one write and one registered read.
// Read-before-write on a shared address. No dependencies.
`default_nettype none

module fdm_echo_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/fdm_out_queue.sv
// Two-entry output queue: output register plus skid entry.
// Space is registered so the pipeline never sees the downstream ready.
`default_nettype none

module fdm_out_queue #(
    parameter int WIDTH = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  space,
    output logic                  tvalid,
    input  wire logic             tready,
    output logic [WIDTH-1:0]      tdata
);
    logic             head_valid_reg;
    logic [WIDTH-1:0] head_data_reg;
    logic             skid_valid_reg;
    logic [WIDTH-1:0] skid_data_reg;
    logic             pop;

    assign pop = head_valid_reg && tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            // Refill the head from the skid entry first, then from the pipe
            head_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= skid_valid_reg && push;
        end
        else if (push)
        begin
            head_valid_reg <= 1'b1;
            skid_valid_reg <= head_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            head_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
            skid_data_reg <= push_data;
        end
        else if (push)
        begin
            if (head_valid_reg)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                head_data_reg <= push_data;
            end
        end
    end

    assign space  = !skid_valid_reg;
    assign tvalid = head_valid_reg;
    assign tdata  = head_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/feedback_delay_mix_unit.sv
// Feedback echo with dry/wet mix: top level, pipeline and configuration.
// Depends on fdm_pkg, fdm_delay_mod, fdm_echo_mem and fdm_out_queue.
`default_nettype none

// Feedback delay mix unit. Each input transaction carries one signed
// Q1.(SAMPLE_BITS-1) sample. The write pointer advances, the sample lying
// delay_samples behind it (modulo DEPTH; zero means a full DEPTH) is read from
// the echo store, sample_in + feedback_gain * delayed is written back at the
// pointer, and wet_mix * delayed + (1 - wet_mix) * sample_in comes out, all
// rounded half up and saturated. The block takes one transaction per clock
// while the output queue has space; results pass stages 1 and 2 into a
// two-entry output queue that lets input continue while a result waits. The
// rate is set by the single read and write port of the echo store: with a
// delay of exactly one sample the next read would need the value still being
// computed, so the input is held until it reaches the hold register and such
// traffic is not taken back to back. A write to delay_samples is reduced
// modulo DEPTH by the reduction unit, and while that unit is busy the slave
// side holds tready low. The store needs no clearing pass after reset: a fill
// mark makes entries not yet written since reset read as zero. Configuration
// must be written only while idle; the block itself does not enforce this.
module feedback_delay_mix_unit #(
    parameter int DEPTH       = fdm_pkg::DEPTH_DEFAULT,
    parameter int SAMPLE_BITS = fdm_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Input sample stream; s_tdata: sample_in [SAMPLE_BITS-1:0], zero padding
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    // Result stream; m_tdata: sample_out [SAMPLE_BITS-1:0], zero padding
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]          m_tdata,
    // Configuration write port
    input  wire logic                                 cfg_we,
    input  wire logic [fdm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [fdm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import fdm_pkg::*;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SB      = SAMPLE_BITS;
    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int FB_W    = SB + GAIN_W;      // delayed * feedback gain
    localparam int MIX_W   = SB + GAIN_W + 1;  // sample * unsigned mix weight
    localparam int ACC_W   = MIX_W + 1;        // wet + dry
    localparam int SUM_W   = SB + 3;           // width before saturation

    // ------------------------------------------------------------------
    // Saturate a widened result back to the sample range
    // ------------------------------------------------------------------
    function automatic logic [SB-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
        logic fits;
        fits = (v[SUM_W-1:SB-1] == '0) || (v[SUM_W-1:SB-1] == '1);
        if (fits)
        begin
            return v[SB-1:0];
        end
        else if (v[SUM_W-1])
        begin
            return {1'b1, {(SB-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(SB-1){1'b1}}};
        end
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [GAIN_W-1:0] feedback_gain_reg;
    logic [GAIN_W-1:0]        mix_reg;
    logic [GAIN_W-1:0]        dry_reg;
    logic [GAIN_W-1:0]        mix_next;
    logic                     delay_load;
    logic                     dm_busy;
    logic [ADDR_W-1:0]        delay_mod;

    // Clamp the wet share to one; the dry share is its complement
    assign mix_next   = (cfg_wdata > GAIN_ONE) ? GAIN_ONE : cfg_wdata;
    assign delay_load = cfg_we && (cfg_index == REG_DELAY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feedback_gain_reg <= FEEDBACK_RESET;
            mix_reg           <= WET_RESET;
            dry_reg           <= GAIN_ONE - WET_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FEEDBACK:
                begin
                    feedback_gain_reg <= $signed(cfg_wdata);
                end
                REG_WET:
                begin
                    mix_reg <= mix_next;
                    dry_reg <= GAIN_ONE - mix_next;
                end
                default:
                begin
                    // Delay goes to the reduction unit; unknown indexes drop
                end
            endcase
        end
    end

    fdm_delay_mod #(
        .DEPTH (DEPTH)
    ) u_delay_mod (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (delay_load),
        .load_value (cfg_wdata[DELAY_W-1:0]),
        .busy       (dm_busy),
        .delay_mod  (delay_mod)
    );

    // ------------------------------------------------------------------
    // Pipeline control: all stages move together when the queue has space
    // ------------------------------------------------------------------
    logic advance;
    logic accept;
    logic hazard;

    // ------------------------------------------------------------------
    // Stage 0: pointer advance, read address, fill check
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] wp_reg;
    logic              wrapped_reg;
    logic [ADDR_W-1:0] wp_new;
    logic [ADDR_W:0]   rd_sum;
    logic [ADDR_W-1:0] rd_next;
    logic              ent_valid_next;

    assign wp_new = (wp_reg == ADDR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rd_sum = {1'b0, wp_new} + (ADDR_W+1)'(DEPTH) - {1'b0, delay_mod};
    assign rd_next = (rd_sum >= (ADDR_W+1)'(DEPTH))
                   ? ADDR_W'(rd_sum - (ADDR_W+1)'(DEPTH))
                   : rd_sum[ADDR_W-1:0];

    // Before the first wrap only entries 1 .. wp_reg are written or in flight
    assign ent_valid_next = wrapped_reg || ((rd_next != '0) && (rd_next <= wp_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (accept)
        begin
            wp_reg <= wp_new;
            if (wp_new == '0)
            begin
                wrapped_reg <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: delayed sample with forwarding, three products
    // ------------------------------------------------------------------
    logic                 s1_valid_reg;
    logic signed [SB-1:0] s1_x_reg;
    logic [ADDR_W-1:0]    s1_wp_reg;
    logic [ADDR_W-1:0]    s1_rd_reg;
    logic                 s1_ent_valid_reg;
    logic [SB-1:0]        mem_rdata;

    // Last write to the store, kept until the next advance
    logic                 hold_valid_reg;
    logic [ADDR_W-1:0]    hold_addr_reg;
    logic [SB-1:0]        hold_data_reg;

    logic signed [SB-1:0]    delayed;
    logic signed [FB_W-1:0]  fb_prod;
    logic signed [MIX_W-1:0] wet_prod;
    logic signed [MIX_W-1:0] dry_prod;

    // The item just ahead would write this read address too late for the read:
    // hold the input until its write lands in the hold register
    assign hazard   = s1_valid_reg && (rd_next == s1_wp_reg);
    assign s_tready = advance && !dm_busy && !hazard;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (hold_valid_reg && (hold_addr_reg == s1_rd_reg))
        begin
            delayed = $signed(hold_data_reg);
        end
        else if (s1_ent_valid_reg)
        begin
            delayed = $signed(mem_rdata);
        end
        else
        begin
            delayed = '0;
        end
    end

    assign fb_prod  = delayed * feedback_gain_reg;
    assign wet_prod = delayed * $signed({1'b0, mix_reg});
    assign dry_prod = s1_x_reg * $signed({1'b0, dry_reg});

    // ------------------------------------------------------------------
    // Stage 2: round, add, saturate; write back and push the result
    // ------------------------------------------------------------------
    logic                    s2_valid_reg;
    logic signed [SB-1:0]    s2_x_reg;
    logic [ADDR_W-1:0]       s2_wp_reg;
    logic signed [FB_W-1:0]  s2_fb_reg;
    logic signed [MIX_W-1:0] s2_wet_reg;
    logic signed [MIX_W-1:0] s2_dry_reg;

    logic signed [FB_W:0]    fb_biased;
    logic signed [SUM_W-1:0] fb_sum;
    logic signed [ACC_W-1:0] acc_biased;
    logic [SB-1:0]           wdata;
    logic [SB-1:0]           ydata;

    assign fb_biased  = (FB_W+1)'(s2_fb_reg) + $signed((FB_W+1)'(ROUND_BIAS));
    assign fb_sum     = SUM_W'($signed(fb_biased[FB_W:GAIN_SHIFT])) + SUM_W'(s2_x_reg);
    assign wdata      = sat_sample(fb_sum);

    assign acc_biased = ACC_W'(s2_wet_reg) + ACC_W'(s2_dry_reg)
                      + $signed(ACC_W'(ROUND_BIAS));
    assign ydata      = sat_sample($signed(acc_biased[ACC_W-1:GAIN_SHIFT]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg   <= accept;
            s2_valid_reg   <= s1_valid_reg;
            hold_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_x_reg         <= $signed(s_tdata[SB-1:0]);
            s1_wp_reg        <= wp_new;
            s1_rd_reg        <= rd_next;
            s1_ent_valid_reg <= ent_valid_next;

            s2_x_reg   <= s1_x_reg;
            s2_wp_reg  <= s1_wp_reg;
            s2_fb_reg  <= fb_prod;
            s2_wet_reg <= wet_prod;
            s2_dry_reg <= dry_prod;

            hold_addr_reg <= s2_wp_reg;
            hold_data_reg <= wdata;
        end
    end

    fdm_echo_mem #(
        .DEPTH (DEPTH),
        .WIDTH (SB)
    ) u_echo_mem (
        .clk     (clk),
        .wr_en   (advance && s2_valid_reg),
        .wr_addr (s2_wp_reg),
        .wr_data (wdata),
        .rd_en   (accept),
        .rd_addr (rd_next),
        .rd_data (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    logic [SB-1:0] q_data;

    fdm_out_queue #(
        .WIDTH (SB)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance && s2_valid_reg),
        .push_data (ydata),
        .space     (advance),
        .tvalid    (m_tvalid),
        .tready    (m_tready),
        .tdata     (q_data)
    );

    assign m_tdata = TDATA_W'(q_data);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A finished result must show up on the master side
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s2_valid_reg) |=> m_tvalid)
        else $error("finished result not presented");

    // The interlock keeps a read from overlapping the write just ahead of it
    a_no_raw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg) |-> (s1_rd_reg != s2_wp_reg))
        else $error("read overlaps a pending write to the same entry");

    // The write pointer moves only with an accepted transaction
    a_wp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready) |=> $stable(wp_reg))
        else $error("write pointer moved without a transaction");

endmodule

`default_nettype wire
